// ----- src/rasi_pkg.sv -----
// Shared types and constants for the ray/box slab intersection unit.
// No dependencies.
`default_nettype none
package rasi_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
        coord_t dir_x;
        coord_t dir_y;
        coord_t dir_z;
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_min_z;
        coord_t box_max_x;
        coord_t box_max_y;
        coord_t box_max_z;
    } ray_box_t;

    typedef struct packed {
        logic   hit;
        coord_t distance;
    } isect_t;

endpackage
`default_nettype wire

// ----- src/rasi_slab_div.sv -----
// Pipelined saturating slab divider: (a - b) * 2^F / den, truncated, clamped.
// Depends on rasi_pkg for defaults. One quotient bit per division stage, W+4 stages.
`default_nettype none
module rasi_slab_div #(
    parameter int W  = rasi_pkg::COORD_WIDTH,
    parameter int F  = rasi_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic [W+3:0]        en,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    input  logic signed [W-1:0] den,
    output logic signed [W-1:0] t
);
    import rasi_pkg::*;

    localparam int NW = W + 1 + F;

    // stage 0: magnitudes and sign
    logic signed [W:0] diff;
    logic [W:0]        mag;
    logic [W-1:0]      dm;
    logic              dneg;
    logic [W:0]        mag_reg;
    logic [W-1:0]      dm0_reg;
    logic              neg0_reg;

    always_comb
    begin
        diff = {a[W-1], a} - {b[W-1], b};
        mag  = diff[W] ? (W+1)'(-diff) : diff;
        dneg = den[W-1];
        dm   = dneg ? W'(-den) : den;
        if (den == '0)
        begin
            dneg = 1'b0;
            dm   = W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag_reg  <= mag;
            dm0_reg  <= dm;
            neg0_reg <= diff[W] ^ dneg;
        end
    end

    // stage 1: overflow check on the high part, seed remainder
    logic [NW-1:0]  num;
    logic [F-1:0]   hi;
    logic [W+F-1:0] hi_ext;
    logic           over1;

    logic [W-1:0] r_s    [W+2];
    logic [W:0]   q_s    [W+2];
    logic [W:0]   low_s  [W+2];
    logic [W-1:0] dm_s   [W+2];
    logic         neg_s  [W+2];
    logic         over_s [W+2];

    always_comb
    begin
        num    = {mag_reg, F'(0)};
        hi     = num[NW-1:W+1];
        hi_ext = {W'(0), hi};
        over1  = hi_ext >= {F'(0), dm0_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            r_s[0]    <= hi_ext[W-1:0];
            q_s[0]    <= '0;
            low_s[0]  <= num[W:0];
            dm_s[0]   <= dm0_reg;
            neg_s[0]  <= neg0_reg;
            over_s[0] <= over1;
        end
    end

    // restoring division, one bit per stage
    for (genvar k = 0; k < W + 1; k++)
    begin : g_step
        logic [W:0] tr;
        logic [W:0] rn;
        logic       ge;

        always_comb
        begin
            tr = {r_s[k], low_s[k][W]};
            ge = tr >= {1'b0, dm_s[k]};
            rn = ge ? (tr - {1'b0, dm_s[k]}) : tr;
        end

        always_ff @(posedge clk)
        begin
            if (en[k+2])
            begin
                r_s[k+1]    <= rn[W-1:0];
                q_s[k+1]    <= {q_s[k][W-1:0], ge};
                low_s[k+1]  <= {low_s[k][W-1:0], 1'b0};
                dm_s[k+1]   <= dm_s[k];
                neg_s[k+1]  <= neg_s[k];
                over_s[k+1] <= over_s[k];
            end
        end
    end

    // last stage: clamp to the signed range
    localparam logic [W:0] CAP = (W+1)'(1) << (W - 1);
    logic [W:0]   qq;
    logic [W-1:0] t_next;
    logic [W-1:0] t_reg;

    always_comb
    begin
        if (neg_s[W+1])
        begin
            qq     = (over_s[W+1] || q_s[W+1] > CAP) ? CAP : q_s[W+1];
            t_next = W'(-qq);
        end
        else
        begin
            qq     = (over_s[W+1] || q_s[W+1] > CAP - 1) ? CAP - 1 : q_s[W+1];
            t_next = qq[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[W+3])
        begin
            t_reg <= t_next;
        end
    end

    assign t = t_reg;

endmodule
`default_nettype wire

// ----- src/ray_aabb_slab_intersect_unit.sv -----
// Top level of the ray versus axis-aligned box slab test.
// Depends on rasi_pkg and rasi_slab_div.
`default_nettype none
// Ray/box intersection by the slab method. Each input transaction carries a
// ray origin, direction and box corners in signed Q16.16; each one yields
// exactly one output transaction with a hit flag and the hit distance
// (0 on miss). The unit is a fixed pipeline of COORD_WIDTH + 7 stages
// (39 at 32 bits): two setup stages, one stage per quotient bit of the six
// parallel slab dividers, a clamp stage, then per-axis ordering, entry/exit
// reduction and the hit decision. A new transaction is taken every cycle
// that in_ready is high. Each stage holds its own valid bit; back-pressure
// only stalls stages up to the first empty one, so bubbles are squeezed
// out while the output waits. A zero direction component acts as one LSB.
module ray_aabb_slab_intersect_unit #(
    parameter int FRAC_BITS = rasi_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rasi_pkg::ray_box_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rasi_pkg::isect_t  out_data
);
    import rasi_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int NS = W + 4;   // divider depth
    localparam int L  = NS + 3;  // total depth

    // stage occupancy and advance chain
    logic [L-1:0] v_reg;
    logic [L-1:0] v_next;
    logic [L-1:0] adv;

    always_comb
    begin
        adv[L-1] = ~v_reg[L-1] | out_ready;
        for (int i = L - 2; i >= 0; i--)
        begin
            adv[i] = ~v_reg[i] | adv[i+1];
        end
        v_next = {v_reg[L-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (adv & v_next) | (~adv & v_reg);
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[L-1];

    // six slab dividers
    coord_t org [3];
    coord_t dir [3];
    coord_t bmin [3];
    coord_t bmax [3];
    coord_t t0 [3];
    coord_t t1 [3];

    assign org[0]  = in_data.origin_x;
    assign org[1]  = in_data.origin_y;
    assign org[2]  = in_data.origin_z;
    assign dir[0]  = in_data.dir_x;
    assign dir[1]  = in_data.dir_y;
    assign dir[2]  = in_data.dir_z;
    assign bmin[0] = in_data.box_min_x;
    assign bmin[1] = in_data.box_min_y;
    assign bmin[2] = in_data.box_min_z;
    assign bmax[0] = in_data.box_max_x;
    assign bmax[1] = in_data.box_max_y;
    assign bmax[2] = in_data.box_max_z;

    for (genvar ax = 0; ax < 3; ax++)
    begin : g_axis
        rasi_slab_div #(
            .W  (W),
            .F  (FRAC_BITS)
        ) u_div_lo (
            .clk (clk),
            .en  (adv[NS-1:0]),
            .a   (bmin[ax]),
            .b   (org[ax]),
            .den (dir[ax]),
            .t   (t0[ax])
        );

        rasi_slab_div #(
            .W  (W),
            .F  (FRAC_BITS)
        ) u_div_hi (
            .clk (clk),
            .en  (adv[NS-1:0]),
            .a   (bmax[ax]),
            .b   (org[ax]),
            .den (dir[ax]),
            .t   (t1[ax])
        );
    end

    // per-axis near/far
    coord_t tn_reg [3];
    coord_t tx_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv[NS])
        begin
            for (int i = 0; i < 3; i++)
            begin
                tn_reg[i] <= (t1[i] < t0[i]) ? t1[i] : t0[i];
                tx_reg[i] <= (t1[i] < t0[i]) ? t0[i] : t1[i];
            end
        end
    end

    // entry = max of nears, exit = min of fars
    coord_t entry_next;
    coord_t exit_next;
    coord_t entry_reg;
    coord_t exit_reg;

    always_comb
    begin
        entry_next = tn_reg[0];
        exit_next  = tx_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (entry_next < tn_reg[i])
            begin
                entry_next = tn_reg[i];
            end
            if (tx_reg[i] < exit_next)
            begin
                exit_next = tx_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS+1])
        begin
            entry_reg <= entry_next;
            exit_reg  <= exit_next;
        end
    end

    // hit decision; origin inside the box reports the exit distance
    isect_t res_next;
    isect_t res_reg;

    always_comb
    begin
        if (exit_reg < entry_reg || exit_reg[W-1])
        begin
            res_next.hit      = 1'b0;
            res_next.distance = '0;
        end
        else
        begin
            res_next.hit      = 1'b1;
            res_next.distance = entry_reg[W-1] ? exit_reg : entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS+2])
        begin
            res_reg <= res_next;
        end
    end

    assign out_data = res_reg;

    // a hit never reports a negative distance
    a_hit_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> !out_data.distance[W-1])
        else $error("hit with negative distance");

    // a miss always reports zero distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.distance == '0)
        else $error("miss with nonzero distance");

    // an empty output stage means the whole pipe can advance
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with free output stage");

endmodule
`default_nettype wire
